// File: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Sizes, entry layout and status codes shared by the queue core.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned PAYLOAD_BITS = 32;
  localparam int unsigned PRIO_W       = 8;
  localparam int unsigned IN_PAYLOAD_W = 32;
  localparam int unsigned OUT_PAYLOAD_W = 32;
  localparam int unsigned CFG_W        = 5;
  localparam int unsigned OUT_COUNT_W  = 5;
  localparam int unsigned ADDR_W       = $clog2(DEPTH);
  localparam int unsigned CNT_W        = $clog2(DEPTH + 1);
  localparam int unsigned ENTRY_W      = PRIO_W + PAYLOAD_BITS;

  localparam logic [CFG_W-1:0] CAPACITY_RESET = CFG_W'(16);

  typedef logic [ENTRY_W-1:0] entry_t;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

endpackage

// File: rtl/spq_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module spq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/sorted_priority_queue_core.sv
// ----------------------------------------------------------------------------
// Sorted priority queue core
// Keeps entries in a RAM sorted by priority, highest first, FIFO among equals.
// A refused operation or a push into an empty queue shows its result in the
// cycle after start. A push moves each lower-ranked entry down one slot, then
// writes the new entry; a pop reads the head, then moves each later entry up
// one slot. Each step uses at most one RAM read and one RAM write. Items are
// taken one at a time. The result strobe lasts one cycle and cannot be stalled.
// Reset clears the count, restores the capacity to 16; the RAM needs no clearing.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               req_type_i,
  input  logic [spq_pkg::IN_PAYLOAD_W-1:0]   payload_i,
  input  logic [spq_pkg::PRIO_W-1:0]         priority_req_i,
  output logic                               done_o,
  output logic [1:0]                         status_o,
  output logic [spq_pkg::OUT_PAYLOAD_W-1:0]  payload_out_o,
  output logic [spq_pkg::OUT_COUNT_W-1:0]    entry_count_o,
  output logic                               is_empty_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [spq_pkg::CFG_W-1:0]          cfg_data_i
);

  import spq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH_CMP,
    S_PUSH_PLACE,
    S_POP_HEAD,
    S_POP_MOVE
  } state_e;

  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [CNT_W-1:0]         pos_q, pos_d;
  logic [CFG_W-1:0]         cap_q;
  entry_t                   new_q, new_d;
  logic                     done_q, done_d;
  logic [1:0]               status_q, status_d;
  logic [OUT_PAYLOAD_W-1:0] pout_q, pout_d;

  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  entry_t                   ram_wdata;
  logic [ADDR_W-1:0]        ram_raddr;
  entry_t                   ram_rdata;

  logic                     accept;
  logic [CFG_W:0]           eff_cap;
  logic                     full;
  entry_t                   in_entry;
  logic [CNT_W-1:0]         pos_m1;
  logic [CNT_W-1:0]         pos_m2;
  logic [CNT_W-1:0]         pos_p1;
  logic [CNT_W-1:0]         count_m1;

  assign accept   = start && !busy;
  assign eff_cap  = ({1'b0, cap_q} < (CFG_W + 1)'(DEPTH)) ? {1'b0, cap_q}
                                                          : (CFG_W + 1)'(DEPTH);
  assign full     = (CFG_W + 1)'(count_q) >= eff_cap;
  assign in_entry = {priority_req_i, PAYLOAD_BITS'(payload_i)};
  assign pos_m1   = pos_q - CNT_W'(1);
  assign pos_m2   = pos_q - CNT_W'(2);
  assign pos_p1   = pos_q + CNT_W'(1);
  assign count_m1 = count_q - CNT_W'(1);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    pos_d     = pos_q;
    new_d     = new_q;
    done_d    = 1'b0;
    status_d  = status_q;
    pout_d    = pout_q;
    ram_we    = 1'b0;
    ram_waddr = pos_q[ADDR_W-1:0];
    ram_wdata = new_q;
    ram_raddr = pos_m1[ADDR_W-1:0];

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          pout_d = '0;
          if (req_type_i == REQ_PUSH) begin
            if (full) begin
              done_d   = 1'b1;
              status_d = STATUS_FULL;
            end else if (count_q == '0) begin
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = in_entry;
              count_d   = count_q + CNT_W'(1);
              done_d    = 1'b1;
              status_d  = STATUS_OK;
            end else begin
              ram_raddr = count_m1[ADDR_W-1:0];
              pos_d     = count_q;
              new_d     = in_entry;
              state_d   = S_PUSH_CMP;
            end
          end else begin
            if (count_q == '0) begin
              done_d   = 1'b1;
              status_d = STATUS_EMPTY;
            end else begin
              ram_raddr = '0;
              state_d   = S_POP_HEAD;
            end
          end
        end
      end

      S_PUSH_CMP: begin
        // Entry at pos-1 is on the read port; move it down while it ranks lower.
        if (ram_rdata[ENTRY_W-1 -: PRIO_W] < new_q[ENTRY_W-1 -: PRIO_W]) begin
          ram_we    = 1'b1;
          ram_waddr = pos_q[ADDR_W-1:0];
          ram_wdata = ram_rdata;
          pos_d     = pos_m1;
          if (pos_m1 == '0) begin
            state_d = S_PUSH_PLACE;
          end else begin
            ram_raddr = pos_m2[ADDR_W-1:0];
          end
        end else begin
          ram_we    = 1'b1;
          ram_waddr = pos_q[ADDR_W-1:0];
          ram_wdata = new_q;
          count_d   = count_q + CNT_W'(1);
          done_d    = 1'b1;
          status_d  = STATUS_OK;
          state_d   = S_IDLE;
        end
      end

      S_PUSH_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q[ADDR_W-1:0];
        ram_wdata = new_q;
        count_d   = count_q + CNT_W'(1);
        done_d    = 1'b1;
        status_d  = STATUS_OK;
        state_d   = S_IDLE;
      end

      S_POP_HEAD: begin
        pout_d   = OUT_PAYLOAD_W'(ram_rdata[PAYLOAD_BITS-1:0]);
        status_d = STATUS_OK;
        if (count_q == CNT_W'(1)) begin
          count_d = count_m1;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          ram_raddr = ADDR_W'(1);
          pos_d     = CNT_W'(1);
          state_d   = S_POP_MOVE;
        end
      end

      S_POP_MOVE: begin
        // Entry at pos is on the read port; it moves up one slot.
        ram_we    = 1'b1;
        ram_waddr = pos_m1[ADDR_W-1:0];
        ram_wdata = ram_rdata;
        if (pos_p1 < count_q) begin
          ram_raddr = pos_p1[ADDR_W-1:0];
          pos_d     = pos_p1;
        end else begin
          count_d = count_m1;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      pos_q    <= '0;
      cap_q    <= CAPACITY_RESET;
      done_q   <= 1'b0;
      status_q <= STATUS_OK;
      pout_q   <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      pos_q    <= pos_d;
      done_q   <= done_d;
      status_q <= status_d;
      pout_q   <= pout_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    new_q <= new_d;
  end

  spq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign busy          = (state_q != S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign payload_out_o = pout_q;
  assign entry_count_o = OUT_COUNT_W'(count_q);
  assign is_empty_o    = (count_q == '0);

endmodule
